// ===== design/awal_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// awal_pkg
// Shared types and constants for the apparent wind aero load core.
// ----------------------------------------------------------------------------
package awal_pkg;

    localparam int IN_W    = 16;   // Q8.8 input vector components
    localparam int REL_W   = 17;   // apparent wind components and speed
    localparam int LOAD_W  = 35;   // force and moment results
    localparam int SUM_W   = 34;   // sum of three squares of 17-bit values
    localparam int ROOT_W  = 17;   // bits in the integer square root
    localparam int CFG_IDX_W = 1;

    typedef logic signed [IN_W-1:0]    t_s16;
    typedef logic signed [REL_W-1:0]   t_s17;
    typedef logic        [REL_W-1:0]   t_u17;
    typedef logic signed [LOAD_W-1:0]  t_s35;
    typedef logic        [SUM_W-1:0]   t_sum;
    typedef logic [CFG_IDX_W-1:0]      t_cfg_idx;

    // configuration register indexes
    localparam t_cfg_idx CFG_DRAG = 1'b0;
    localparam t_cfg_idx CFG_YAW  = 1'b1;

endpackage

// ===== design/apparent_wind_aero_load_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// apparent_wind_aero_load_core
// Apparent wind, its magnitude and the drag, lateral and yaw loads.
// ----------------------------------------------------------------------------
// One item per clock cycle sustained while the result side takes results.
// The pipeline is a square root that resolves one root bit per pipeline stage
// over 17 stages, plus an input stage, a multiply stage, a sum-of-squares
// stage and a final scaling multiply stage. The whole pipeline advances
// whenever the result register is empty or being taken, so bubbles and
// stalls on either side lose nothing.
// Coefficients may only be written while no item is in flight.
module apparent_wind_aero_load_core #(
    parameter int REF_SPEED_Q8 = 90
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // configuration
    input  logic                i_cfg_we,
    input  awal_pkg::t_cfg_idx  i_cfg_idx,
    input  awal_pkg::t_s16      i_cfg_data,
    // input items
    input  logic                i_valid,
    output logic                o_ready,
    input  awal_pkg::t_s16      i_wind_x,
    input  awal_pkg::t_s16      i_wind_y,
    input  awal_pkg::t_s16      i_wind_z,
    input  awal_pkg::t_s16      i_hull_vel_x,
    input  awal_pkg::t_s16      i_hull_vel_y,
    input  awal_pkg::t_s16      i_hull_vel_z,
    // result items
    output logic                o_valid,
    input  logic                i_ready,
    output awal_pkg::t_s17      o_rel_x,
    output awal_pkg::t_s17      o_rel_y,
    output awal_pkg::t_s17      o_rel_z,
    output awal_pkg::t_u17      o_rel_speed,
    output awal_pkg::t_s35      o_force_long,
    output awal_pkg::t_s35      o_force_lat,
    output awal_pkg::t_s35      o_yaw_moment
);
    import awal_pkg::*;

    localparam int SQ_STAGES = ROOT_W;            // one root bit per stage
    localparam int NSTG      = SQ_STAGES + 4;     // in, mul, sum, sqrt, scale
    localparam int PRD_W     = IN_W + REL_W;      // coeff x component
    localparam int Q_W       = PRD_W - 8;         // after Q.8 truncation
    localparam int SPD_W     = ROOT_W + 1;        // speed as a signed operand
    localparam int M_W       = Q_W + SPD_W;       // scaled load before shift

    // configuration
    t_s16 r_cfg_drag;
    t_s16 r_cfg_yaw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_drag <= '0;
            r_cfg_yaw  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_DRAG: r_cfg_drag <= i_cfg_data;
                CFG_YAW:  r_cfg_yaw  <= i_cfg_data;
                default:  ;
            endcase
        end
    end

    // pipeline control: everything moves when the result slot frees up
    logic            w_adv;
    logic [NSTG-1:0] r_v;

    assign w_adv   = !r_v[NSTG-1] || i_ready;
    assign o_ready = w_adv;
    assign o_valid = r_v[NSTG-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (w_adv) begin
            r_v <= {r_v[NSTG-2:0], i_valid};
        end
    end

    // stage 0: apparent wind
    t_s17 r_s0_rx, r_s0_ry, r_s0_rz;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s0_rx <= REL_W'(i_wind_x) - REL_W'(i_hull_vel_x);
            r_s0_ry <= REL_W'(i_wind_y) - REL_W'(i_hull_vel_y);
            r_s0_rz <= REL_W'(i_wind_z) - REL_W'(i_hull_vel_z);
        end
    end

    // stage 1: squares and coefficient products
    logic        [2*REL_W-3:0] r_s1_sqx, r_s1_sqy, r_s1_sqz;
    logic signed [PRD_W-1:0]   r_s1_pl, r_s1_pt, r_s1_py;
    t_s17                      r_s1_rx, r_s1_ry, r_s1_rz;
    logic signed [2*REL_W-1:0] w_sqx, w_sqy, w_sqz;

    assign w_sqx = r_s0_rx * r_s0_rx;
    assign w_sqy = r_s0_ry * r_s0_ry;
    assign w_sqz = r_s0_rz * r_s0_rz;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            // |r| <= 65535, so each square fits in 32 bits
            r_s1_sqx <= w_sqx[2*REL_W-3:0];
            r_s1_sqy <= w_sqy[2*REL_W-3:0];
            r_s1_sqz <= w_sqz[2*REL_W-3:0];
            r_s1_pl  <= PRD_W'(r_cfg_drag) * PRD_W'(r_s0_rx);
            r_s1_pt  <= PRD_W'(r_cfg_drag) * PRD_W'(r_s0_ry);
            r_s1_py  <= PRD_W'(r_cfg_yaw)  * PRD_W'(r_s0_ry);
            r_s1_rx  <= r_s0_rx;
            r_s1_ry  <= r_s0_ry;
            r_s1_rz  <= r_s0_rz;
        end
    end

    // stage 2: sum of squares, products truncated to Q.8
    t_sum                  r_s2_sum;
    logic signed [Q_W-1:0] r_s2_ql, r_s2_qt, r_s2_qy;
    t_s17                  r_s2_rx, r_s2_ry, r_s2_rz;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s2_sum <= SUM_W'(r_s1_sqx) + SUM_W'(r_s1_sqy) + SUM_W'(r_s1_sqz);
            r_s2_ql  <= r_s1_pl[PRD_W-1:8];
            r_s2_qt  <= r_s1_pt[PRD_W-1:8];
            r_s2_qy  <= r_s1_py[PRD_W-1:8];
            r_s2_rx  <= r_s1_rx;
            r_s2_ry  <= r_s1_ry;
            r_s2_rz  <= r_s1_rz;
        end
    end

    // square root: digit-by-digit, one root bit per stage
    t_sum                  r_q_rem [SQ_STAGES];
    t_sum                  r_q_res [SQ_STAGES];
    logic signed [Q_W-1:0] r_q_ql  [SQ_STAGES];
    logic signed [Q_W-1:0] r_q_qt  [SQ_STAGES];
    logic signed [Q_W-1:0] r_q_qy  [SQ_STAGES];
    t_s17                  r_q_rx  [SQ_STAGES];
    t_s17                  r_q_ry  [SQ_STAGES];
    t_s17                  r_q_rz  [SQ_STAGES];

    for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
        localparam t_sum BIT = t_sum'(1) << (2 * (SQ_STAGES - 1 - k));

        t_sum                  w_rem, w_res;
        logic signed [Q_W-1:0] w_ql, w_qt, w_qy;
        t_s17                  w_rx, w_ry, w_rz;
        logic [SUM_W:0]        w_try;
        logic                  w_take;

        if (k == 0) begin : g_first
            assign w_rem = r_s2_sum;
            assign w_res = '0;
            assign w_ql  = r_s2_ql;
            assign w_qt  = r_s2_qt;
            assign w_qy  = r_s2_qy;
            assign w_rx  = r_s2_rx;
            assign w_ry  = r_s2_ry;
            assign w_rz  = r_s2_rz;
        end else begin : g_next
            assign w_rem = r_q_rem[k-1];
            assign w_res = r_q_res[k-1];
            assign w_ql  = r_q_ql[k-1];
            assign w_qt  = r_q_qt[k-1];
            assign w_qy  = r_q_qy[k-1];
            assign w_rx  = r_q_rx[k-1];
            assign w_ry  = r_q_ry[k-1];
            assign w_rz  = r_q_rz[k-1];
        end

        assign w_try  = {1'b0, w_res} + {1'b0, BIT};
        assign w_take = {1'b0, w_rem} >= w_try;

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                if (w_take) begin
                    r_q_rem[k] <= w_rem - w_try[SUM_W-1:0];
                    r_q_res[k] <= (w_res >> 1) + BIT;
                end else begin
                    r_q_rem[k] <= w_rem;
                    r_q_res[k] <= w_res >> 1;
                end
                r_q_ql[k] <= w_ql;
                r_q_qt[k] <= w_qt;
                r_q_qy[k] <= w_qy;
                r_q_rx[k] <= w_rx;
                r_q_ry[k] <= w_ry;
                r_q_rz[k] <= w_rz;
            end
        end
    end

    // final stage: scale by speed (drag loads by speed plus REF_SPEED_Q8)
    t_u17                  w_speed, w_dspd;
    logic signed [M_W-1:0] r_s3_ml, r_s3_mt, r_s3_my;
    t_u17                  r_s3_speed;
    t_s17                  r_s3_rx, r_s3_ry, r_s3_rz;

    assign w_speed = r_q_res[SQ_STAGES-1][ROOT_W-1:0];
    assign w_dspd  = w_speed + REL_W'(REF_SPEED_Q8);

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s3_ml    <= M_W'(r_q_ql[SQ_STAGES-1]) * M_W'($signed({1'b0, w_dspd}));
            r_s3_mt    <= M_W'(r_q_qt[SQ_STAGES-1]) * M_W'($signed({1'b0, w_dspd}));
            r_s3_my    <= M_W'(r_q_qy[SQ_STAGES-1]) * M_W'($signed({1'b0, w_speed}));
            r_s3_speed <= w_speed;
            r_s3_rx    <= r_q_rx[SQ_STAGES-1];
            r_s3_ry    <= r_q_ry[SQ_STAGES-1];
            r_s3_rz    <= r_q_rz[SQ_STAGES-1];
        end
    end

    // lateral: Q.8 truncation then halving is one floor shift by 9
    assign o_rel_x      = r_s3_rx;
    assign o_rel_y      = r_s3_ry;
    assign o_rel_z      = r_s3_rz;
    assign o_rel_speed  = r_s3_speed;
    assign o_force_long = r_s3_ml[LOAD_W+7:8];
    assign o_force_lat  = {r_s3_mt[LOAD_W+7], r_s3_mt[LOAD_W+7:9]};
    assign o_yaw_moment = r_s3_my[LOAD_W+7:8];

    // checks
    t_u17 w_abs_x;
    assign w_abs_x = o_rel_x[REL_W-1] ? t_u17'(-o_rel_x) : t_u17'(o_rel_x);

    a_zero_wind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rel_x == '0 && o_rel_y == '0 && o_rel_z == '0)
            |-> (o_rel_speed == '0 && o_yaw_moment == '0))
        else $error("zero apparent wind gave nonzero speed or yaw");

    a_zero_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rel_y == '0) |-> (o_force_lat == '0 && o_yaw_moment == '0))
        else $error("zero lateral wind gave lateral load");

    a_speed_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_rel_speed >= w_abs_x))
        else $error("speed below magnitude of x component");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_adv |=> $stable(r_v))
        else $error("pipeline occupancy changed during stall");

endmodule
